// ----- hdl/mpg_pkg.sv -----
// ----------------------------------------------------------------------------
// mpg_pkg
// Shared types and constants for the gap-limited max product block.
// ----------------------------------------------------------------------------
`default_nettype none

package mpg_pkg;

    localparam int MAX_N  = 64;
    localparam int MAX_K  = 8;
    localparam int POS_W  = $clog2(MAX_N);
    localparam int KI_W   = $clog2(MAX_K);
    localparam int ADDR_W = POS_W + KI_W;
    localparam int DEPTH  = MAX_N * MAX_K;
    localparam int PROD_W = 64;

    // configuration register indexes
    localparam logic [1:0] CFG_CHOOSE = 2'd0;
    localparam logic [1:0] CFG_GAP    = 2'd1;

    // one table entry: reach mark plus largest and smallest product
    typedef struct packed {
        logic              reach;
        logic [PROD_W-1:0] hi;
        logic [PROD_W-1:0] lo;
    } entry_t;

    // control from sequencer to accumulator
    typedef struct packed {
        logic clr;
        logic rd_valid;
    } acc_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/max_product_gap_limited_choice.sv -----
// ----------------------------------------------------------------------------
// max_product_gap_limited_choice
// Largest product of exactly choose_count values, consecutive picks at most
// max_gap apart, over a sequence closed by tlast.
// ----------------------------------------------------------------------------
// An item passes from accept to the next ready through the accept in S_IDLE,
// then a setup and a write state for each of the eight counts. For each
// count 2 up to choose_count the sequencer also reads one earlier row per
// cycle from the single-read-port table RAM. That is up to max_gap rows,
// fewer near the start of a sequence, followed by a drain of the multiply
// pipeline in S_DRAIN. The closing beat adds the S_EMIT state to load the
// result register, and stays there while an earlier result is still waiting.
// Values past the 64th of a sequence are dropped (overflow flag) and skip
// the table. The table needs no clearing: every row read belongs to the
// current sequence.
`default_nettype none

module max_product_gap_limited_choice (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream; s_tdata: [7:0] value
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        s_tlast,
    // result stream; m_tdata: [63:0] best_product
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,
    // m_tuser: [0] found, [1] overflow
    output logic [1:0]       m_tuser,
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW,
        S_ISSUE,
        S_DRAIN,
        S_WRITE,
        S_EMIT
    } state_t;

    localparam int POS_W = mpg_pkg::POS_W;
    localparam int KI_W  = mpg_pkg::KI_W;

    state_t                    state_reg;
    logic [3:0]                choose_reg;
    logic [5:0]                gap_reg;
    logic [3:0]                k_reg;
    logic [5:0]                g_reg;
    logic signed [7:0]         v_reg;
    logic                      last_reg;
    logic [POS_W:0]            pos_reg;
    logic [KI_W-1:0]           j_reg;
    logic [POS_W-1:0]          m_reg;
    logic                      drain_reg;
    logic                      rd_pend_reg;
    logic signed [63:0]        best_reg;
    logic                      best_v_reg;
    logic                      drop_reg;
    logic                      out_v_reg;
    logic [63:0]               out_prod_reg;
    logic [1:0]                out_user_reg;

    logic [POS_W:0]            first;
    logic [4:0]                jnum;
    logic                      j_in_k;
    logic                      rd_en;
    logic [mpg_pkg::ADDR_W-1:0] rd_addr;
    logic [mpg_pkg::ADDR_W-1:0] wr_addr;
    logic                      wr_en;
    mpg_pkg::entry_t           wr_entry;
    mpg_pkg::entry_t           rd_entry;
    mpg_pkg::entry_t           acc;
    mpg_pkg::acc_ctl_t         acc_ctl;
    logic                      out_free;
    logic                      emit_now;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_v_reg;
    assign m_tdata   = out_prod_reg;
    assign m_tuser   = out_user_reg;
    assign out_free  = !out_v_reg || m_tready;
    assign emit_now  = (state_reg == S_EMIT) && out_free;

    // scan window start and count of the current row
    assign first  = (pos_reg > (POS_W+1)'(g_reg)) ? pos_reg - (POS_W+1)'(g_reg) : '0;
    assign jnum   = 5'(j_reg) + 5'd1;
    assign j_in_k = (jnum <= 5'(k_reg));

    assign rd_en   = (state_reg == S_ISSUE);
    assign rd_addr = {m_reg, KI_W'(j_reg - KI_W'(1))};
    assign wr_en   = (state_reg == S_WRITE);
    assign wr_addr = {pos_reg[POS_W-1:0], j_reg};

    assign acc_ctl.clr      = (state_reg == S_ROW);
    assign acc_ctl.rd_valid = rd_pend_reg;

    // cell contents: a first pick is the value itself
    always_comb
    begin
        if (j_reg == '0)
        begin
            wr_entry.reach = j_in_k;
            wr_entry.hi    = 64'(v_reg);
            wr_entry.lo    = 64'(v_reg);
        end
        else
        begin
            wr_entry.reach = acc.reach && j_in_k;
            wr_entry.hi    = acc.hi;
            wr_entry.lo    = acc.lo;
        end
    end

    mpg_ram #(
        .WIDTH ($bits(mpg_pkg::entry_t)),
        .DEPTH (mpg_pkg::DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    mpg_acc u_acc (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (acc_ctl),
        .value    (v_reg),
        .rd_entry (rd_entry),
        .acc      (acc)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            choose_reg <= 4'd1;
            gap_reg    <= 6'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mpg_pkg::CFG_CHOOSE: choose_reg <= cfg_data[3:0];
                mpg_pkg::CFG_GAP:    gap_reg    <= cfg_data[5:0];
                default:             ;
            endcase
        end
    end

    // item payload latched at accept
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            v_reg <= s_tdata;
            k_reg <= choose_reg;
            g_reg <= gap_reg;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            last_reg     <= 1'b0;
            pos_reg      <= '0;
            j_reg        <= '0;
            m_reg        <= '0;
            drain_reg    <= 1'b0;
            rd_pend_reg  <= 1'b0;
            best_reg     <= '0;
            best_v_reg   <= 1'b0;
            drop_reg     <= 1'b0;
            out_v_reg    <= 1'b0;
            out_prod_reg <= '0;
            out_user_reg <= '0;
        end
        else
        begin
            rd_pend_reg <= rd_en;
            if (m_tready && !emit_now)
            begin
                out_v_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        last_reg <= s_tlast;
                        j_reg    <= '0;
                        if (pos_reg < (POS_W+1)'(mpg_pkg::MAX_N))
                        begin
                            state_reg <= S_ROW;
                        end
                        else
                        begin
                            drop_reg  <= 1'b1;
                            state_reg <= s_tlast ? S_EMIT : S_IDLE;
                        end
                    end
                end
                S_ROW:
                begin
                    m_reg <= first[POS_W-1:0];
                    if (j_reg != '0 && j_in_k && first < pos_reg)
                    begin
                        state_reg <= S_ISSUE;
                    end
                    else
                    begin
                        state_reg <= S_WRITE;
                    end
                end
                S_ISSUE:
                begin
                    m_reg <= m_reg + POS_W'(1);
                    if ((POS_W+1)'(m_reg) == pos_reg - (POS_W+1)'(1))
                    begin
                        drain_reg <= 1'b0;
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    drain_reg <= 1'b1;
                    if (drain_reg)
                    begin
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    if (wr_entry.reach && jnum == 5'(k_reg))
                    begin
                        if (!best_v_reg || $signed(wr_entry.hi) > best_reg)
                        begin
                            best_reg <= wr_entry.hi;
                        end
                        best_v_reg <= 1'b1;
                    end
                    if (j_reg == KI_W'(mpg_pkg::MAX_K - 1))
                    begin
                        pos_reg   <= pos_reg + (POS_W+1)'(1);
                        state_reg <= last_reg ? S_EMIT : S_IDLE;
                    end
                    else
                    begin
                        j_reg     <= j_reg + KI_W'(1);
                        state_reg <= S_ROW;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_v_reg    <= 1'b1;
                        out_prod_reg <= best_v_reg ? best_reg : '0;
                        out_user_reg <= {drop_reg, best_v_reg};
                        pos_reg      <= '0;
                        best_reg     <= '0;
                        best_v_reg   <= 1'b0;
                        drop_reg     <= 1'b0;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hdl/mpg_ram.sv -----
// ----------------------------------------------------------------------------
// mpg_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mpg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/mpg_acc.sv -----
// ----------------------------------------------------------------------------
// mpg_acc
// Multiplies predecessor extremes by the new value and folds them into the
// running largest / smallest product of one table cell.
// ----------------------------------------------------------------------------
`default_nettype none

module mpg_acc (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mpg_pkg::acc_ctl_t ctl,
    input  wire logic signed [7:0] value,
    input  wire mpg_pkg::entry_t   rd_entry,
    output mpg_pkg::entry_t        acc
);

    logic                                 mul_v_reg;
    logic signed [mpg_pkg::PROD_W-1:0]    a_reg, b_reg;
    logic signed [mpg_pkg::PROD_W-1:0]    a_next, b_next;
    logic signed [mpg_pkg::PROD_W-1:0]    big, small_v;
    logic                                 ok_reg;
    logic signed [mpg_pkg::PROD_W-1:0]    hi_reg, lo_reg;

    // products of stored extremes by the new value
    assign a_next = $signed(rd_entry.hi) * mpg_pkg::PROD_W'(value);
    assign b_next = $signed(rd_entry.lo) * mpg_pkg::PROD_W'(value);

    assign big     = (a_reg > b_reg) ? a_reg : b_reg;
    assign small_v = (a_reg < b_reg) ? a_reg : b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_v_reg <= 1'b0;
            ok_reg    <= 1'b0;
        end
        else
        begin
            mul_v_reg <= ctl.rd_valid && rd_entry.reach && !ctl.clr;
            if (ctl.clr)
            begin
                ok_reg <= 1'b0;
            end
            else if (mul_v_reg)
            begin
                ok_reg <= 1'b1;
            end
        end
    end

    // multiply stage and fold stage payload
    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        if (mul_v_reg && !ctl.clr)
        begin
            if (!ok_reg || big > hi_reg)
            begin
                hi_reg <= big;
            end
            if (!ok_reg || small_v < lo_reg)
            begin
                lo_reg <= small_v;
            end
        end
    end

    assign acc.reach = ok_reg;
    assign acc.hi    = hi_reg;
    assign acc.lo    = lo_reg;

endmodule

`default_nettype wire

// ----- hdl/mpg_checker.sv -----
// ----------------------------------------------------------------------------
// mpg_checker
// Port-level checks for the gap-limited max product block.
// ----------------------------------------------------------------------------
`default_nettype none

module mpg_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // no choice found means a zero product
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == 64'd0)
        else $error("nonzero product without found");

    // reset empties the result register
    a_rst: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("result valid during reset");

    // a new result beat is loaded while the input side is busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result loaded while input ready");

endmodule

bind max_product_gap_limited_choice mpg_checker u_mpg_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
